/* design/olib_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olib_pkg
// Shared types and constants of the ordered list insert-before core: result
// status codes, operation codes, fixed field widths and the store write-enable group.
// ----------------------------------------------------------------------------
package olib_pkg;

   // fixed widths of the beat fields
   localparam int VAL_W = 32;
   localparam int POS_W = 7;
   localparam int RP_W  = 6;
   localparam int ST_W  = 3;

   // result status codes
   typedef enum logic [ST_W-1:0] {
      ST_BEFORE     = 3'd0,
      ST_HEAD       = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_FULL       = 3'd3,
      ST_READ_OK    = 3'd4,
      ST_READ_RANGE = 3'd5
   } status_type;

   // operation codes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   // write enables from the sequencer to the list store
   typedef struct packed {
      logic val_we;
      logic link_we;
   } store_we_type;

endpackage

/* design/olib_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olib_store
// Value and link memories of the list. One write port per memory, one shared
// read address, registered read data.
// ----------------------------------------------------------------------------
module olib_store #(
   parameter int LIST_DEPTH = 64,
   parameter int ADDR_W     = 6,
   parameter int PTR_W      = 7
) (
   input  logic                            clock,
   input  olib_pkg::store_we_type          wr_en,
   input  logic [ADDR_W-1:0]               val_addr,
   input  logic signed [olib_pkg::VAL_W-1:0] val_data,
   input  logic [ADDR_W-1:0]               link_addr,
   input  logic [PTR_W-1:0]                link_data,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic signed [olib_pkg::VAL_W-1:0] rd_val,
   output logic [PTR_W-1:0]                rd_link
);

   logic signed [olib_pkg::VAL_W-1:0] val_mem [LIST_DEPTH];
   logic [PTR_W-1:0]                  link_mem [LIST_DEPTH];
   logic signed [olib_pkg::VAL_W-1:0] rd_val_ff;
   logic [PTR_W-1:0]                  rd_link_ff;

   // write values and links, read both at the walk address
   always_ff @(posedge clock) begin
      if (wr_en.val_we) begin
         val_mem[val_addr] <= val_data;
      end
      if (wr_en.link_we) begin
         link_mem[link_addr] <= link_data;
      end
      rd_val_ff  <= val_mem[rd_addr];
      rd_link_ff <= link_mem[rd_addr];
   end

   assign rd_val  = rd_val_ff;
   assign rd_link = rd_link_ff;

endmodule

/* design/olib_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olib_seq
// Sequencer of the list core: holds head pointer and fill count, walks the
// list one element per cycle through a single value compare, and issues the
// link updates and the result beat.
// ----------------------------------------------------------------------------
module olib_seq #(
   parameter int LIST_DEPTH = 64,
   parameter int ADDR_W     = 6,
   parameter int PTR_W      = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic signed [olib_pkg::VAL_W-1:0] req_ref_value,
   input  logic signed [olib_pkg::VAL_W-1:0] req_new_value,
   input  logic [olib_pkg::RP_W-1:0]         req_read_position,
   output logic                              rsp_valid,
   output logic [olib_pkg::ST_W-1:0]         rsp_status,
   output logic [olib_pkg::POS_W-1:0]        rsp_insert_position,
   output logic [olib_pkg::POS_W-1:0]        rsp_list_length,
   output logic signed [olib_pkg::VAL_W-1:0] rsp_read_data,
   output olib_pkg::store_we_type            wr_en,
   output logic [ADDR_W-1:0]                 val_addr,
   output logic signed [olib_pkg::VAL_W-1:0] val_data,
   output logic [ADDR_W-1:0]                 link_addr,
   output logic [PTR_W-1:0]                  link_data,
   output logic [ADDR_W-1:0]                 rd_addr,
   input  logic signed [olib_pkg::VAL_W-1:0] rd_val,
   input  logic [PTR_W-1:0]                  rd_link
);

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(LIST_DEPTH);
   localparam int CMP_W = (PTR_W > olib_pkg::RP_W) ? PTR_W : olib_pkg::RP_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS_WALK,
      S_INS_LINK,
      S_RD_WALK
   } state_type;

   state_type                         state_ff, state_in;
   logic [PTR_W-1:0]                  head_ff, head_in;
   logic [PTR_W-1:0]                  fill_ff, fill_in;
   logic signed [olib_pkg::VAL_W-1:0] ref_ff, ref_in;
   logic [PTR_W-1:0]                  slot_ff, slot_in;
   logic [ADDR_W-1:0]                 prev_ff, prev_in;
   logic [PTR_W-1:0]                  cur_ff, cur_in;
   logic [PTR_W-1:0]                  pos_ff, pos_in;
   logic [olib_pkg::RP_W-1:0]         remain_ff, remain_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   olib_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [olib_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [olib_pkg::POS_W-1:0]        rsp_len_ff, rsp_len_in;
   logic signed [olib_pkg::VAL_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic match;
   logic link_null;
   logic full;
   logic rd_range;

   assign accept    = start && (state_ff == S_IDLE);
   assign match     = (rd_val == ref_ff);
   assign link_null = (rd_link == NULL_PTR);
   assign full      = (fill_ff == NULL_PTR);
   assign rd_range  = (CMP_W'(req_read_position) >= CMP_W'(fill_ff));

   // new value always lands in the next free entry
   assign val_addr = ADDR_W'(fill_ff);
   assign val_data = req_new_value;

   // next state, store accesses and result beat
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      ref_in        = ref_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = '0;
      link_addr     = ADDR_W'(slot_ff);
      link_data     = cur_ff;
      rd_addr       = ADDR_W'(head_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_pos_in  = '0;
               rsp_data_in = '0;
               ref_in      = req_ref_value;
               slot_in     = fill_ff;
               cur_in      = head_ff;
               pos_in      = '0;
               remain_in   = req_read_position;
               if (req_op == olib_pkg::OP_INSERT) begin
                  if (full) begin
                     // drop the insert
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = olib_pkg::ST_FULL;
                     rsp_len_in    = olib_pkg::POS_W'(fill_ff);
                  end else if (head_ff == NULL_PTR) begin
                     // empty list: new entry becomes the head
                     wr_en.val_we  = 1'b1;
                     wr_en.link_we = 1'b1;
                     link_addr     = ADDR_W'(fill_ff);
                     link_data     = head_ff;
                     head_in       = fill_ff;
                     fill_in       = fill_ff + PTR_W'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = olib_pkg::ST_HEAD;
                     rsp_len_in    = olib_pkg::POS_W'(fill_in);
                  end else begin
                     wr_en.val_we = 1'b1;
                     state_in     = S_INS_WALK;
                  end
               end else begin
                  if (rd_range) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = olib_pkg::ST_READ_RANGE;
                     rsp_len_in    = olib_pkg::POS_W'(fill_ff);
                  end else begin
                     state_in = S_RD_WALK;
                  end
               end
            end
         end

         S_INS_WALK: begin
            if (match) begin
               // link the new entry in front of the match
               wr_en.link_we = 1'b1;
               link_data     = cur_ff;
               if (pos_ff == '0) begin
                  head_in       = slot_ff;
                  fill_in       = fill_ff + PTR_W'(1);
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = olib_pkg::ST_HEAD;
                  rsp_len_in    = olib_pkg::POS_W'(fill_in);
               end else begin
                  state_in = S_INS_LINK;
               end
            end else if (link_null) begin
               // no match: new entry becomes the head
               wr_en.link_we = 1'b1;
               link_data     = head_ff;
               head_in       = slot_ff;
               fill_in       = fill_ff + PTR_W'(1);
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = olib_pkg::ST_NOT_FOUND;
               rsp_len_in    = olib_pkg::POS_W'(fill_in);
            end else begin
               // advance one link
               prev_in = ADDR_W'(cur_ff);
               cur_in  = rd_link;
               pos_in  = pos_ff + PTR_W'(1);
               rd_addr = ADDR_W'(rd_link);
            end
         end

         S_INS_LINK: begin
            // point the predecessor at the new entry
            wr_en.link_we = 1'b1;
            link_addr     = prev_ff;
            link_data     = slot_ff;
            fill_in       = fill_ff + PTR_W'(1);
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = olib_pkg::ST_BEFORE;
            rsp_pos_in    = olib_pkg::POS_W'(pos_ff);
            rsp_len_in    = olib_pkg::POS_W'(fill_in);
         end

         S_RD_WALK: begin
            if (remain_ff == '0) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = olib_pkg::ST_READ_OK;
               rsp_data_in   = rd_val;
               rsp_len_in    = olib_pkg::POS_W'(fill_ff);
            end else if (link_null) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = olib_pkg::ST_READ_RANGE;
               rsp_len_in    = olib_pkg::POS_W'(fill_ff);
            end else begin
               remain_in = remain_ff - olib_pkg::RP_W'(1);
               rd_addr   = ADDR_W'(rd_link);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_PTR;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ref_ff        <= ref_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      remain_ff     <= remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_insert_position = rsp_pos_ff;
   assign rsp_list_length     = rsp_len_ff;
   assign rsp_read_data       = rsp_data_ff;

endmodule

/* design/ordered_list_insert_before_core.sv */
`timescale 1ns / 1ps
// Results: for a full store, an empty list or a read past the end, the result
//   beat follows in the cycle after accept; otherwise an insert walks the list
//   in S_INS_WALK (then S_INS_LINK mid-list) and a read walks it in S_RD_WALK.
// Throughput: one item at a time; the list walk visits one element per cycle.
// Reset: empties the list (head null, fill count zero); memories are not cleared.
// The result beat is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// ordered_list_insert_before_core
// Singly linked list of signed values with insert-before-reference and
// read-at-position commands.
// ----------------------------------------------------------------------------
module ordered_list_insert_before_core #(
   parameter int LIST_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic signed [olib_pkg::VAL_W-1:0] req_ref_value,
   input  logic signed [olib_pkg::VAL_W-1:0] req_new_value,
   input  logic [olib_pkg::RP_W-1:0]         req_read_position,
   output logic                              rsp_valid,
   output logic [olib_pkg::ST_W-1:0]         rsp_status,
   output logic [olib_pkg::POS_W-1:0]        rsp_insert_position,
   output logic [olib_pkg::POS_W-1:0]        rsp_list_length,
   output logic signed [olib_pkg::VAL_W-1:0] rsp_read_data
);

   localparam int ADDR_W = (LIST_DEPTH > 2) ? $clog2(LIST_DEPTH) : 1;
   localparam int PTR_W  = $clog2(LIST_DEPTH + 1);

   olib_pkg::store_we_type            wr_en;
   logic [ADDR_W-1:0]                 val_addr;
   logic signed [olib_pkg::VAL_W-1:0] val_data;
   logic [ADDR_W-1:0]                 link_addr;
   logic [PTR_W-1:0]                  link_data;
   logic [ADDR_W-1:0]                 rd_addr;
   logic signed [olib_pkg::VAL_W-1:0] rd_val;
   logic [PTR_W-1:0]                  rd_link;

   // walk and update sequencer
   olib_seq #(
      .LIST_DEPTH (LIST_DEPTH),
      .ADDR_W     (ADDR_W),
      .PTR_W      (PTR_W)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_ref_value       (req_ref_value),
      .req_new_value       (req_new_value),
      .req_read_position   (req_read_position),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_insert_position (rsp_insert_position),
      .rsp_list_length     (rsp_list_length),
      .rsp_read_data       (rsp_read_data),
      .wr_en               (wr_en),
      .val_addr            (val_addr),
      .val_data            (val_data),
      .link_addr           (link_addr),
      .link_data           (link_data),
      .rd_addr             (rd_addr),
      .rd_val              (rd_val),
      .rd_link             (rd_link)
   );

   // value and link memories
   olib_store #(
      .LIST_DEPTH (LIST_DEPTH),
      .ADDR_W     (ADDR_W),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .val_addr  (val_addr),
      .val_data  (val_data),
      .link_addr (link_addr),
      .link_data (link_data),
      .rd_addr   (rd_addr),
      .rd_val    (rd_val),
      .rd_link   (rd_link)
   );

endmodule

/* design/olib_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olib_chk
// Port-level checks of the list core: command/result sequencing and result
// field consistency. Bound to the top level.
// ----------------------------------------------------------------------------
module olib_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [olib_pkg::ST_W-1:0]         rsp_status,
   input logic [olib_pkg::POS_W-1:0]        rsp_insert_position,
   input logic signed [olib_pkg::VAL_W-1:0] rsp_read_data
);

   // an accepted beat either keeps the core busy or answers next cycle
   a_accept_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither busy nor answered");

   // the core goes idle only together with a result beat
   a_fell_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   // no result beat while a walk is in flight
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   // head, not-found and dropped inserts report position zero
   a_head_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == olib_pkg::ST_HEAD ||
                     rsp_status == olib_pkg::ST_NOT_FOUND ||
                     rsp_status == olib_pkg::ST_FULL)) |-> (rsp_insert_position == '0))
      else $error("nonzero position on head or dropped insert");

   // read data is zero unless a read succeeded
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != olib_pkg::ST_READ_OK)) |-> (rsp_read_data == '0))
      else $error("nonzero read data without a good read");

endmodule

bind ordered_list_insert_before_core olib_chk u_olib_chk (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_status          (rsp_status),
   .rsp_insert_position (rsp_insert_position),
   .rsp_read_data       (rsp_read_data)
);

/* verif/ordered_list_insert_before_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_before_core_tb
// Drives insert and read commands into the linked-list core and keeps a
// shadow copy of the list (values, links, head, fill count). Each accepted
// command updates the shadow and queues the beat it must produce; each result
// strobe is checked field by field against the oldest queued beat. Stimulus
// is a short directed list walk followed by RANDOM_ITEMS random inserts and
// reads that often reference values sent by earlier inserts, run well past a full store.
// ----------------------------------------------------------------------------
module ordered_list_insert_before_core_tb;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 530;
   // longest command walks the full list; gaps from the sender are short
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam logic [olib_pkg::VAL_W-1:0] MAX_POS = 32'h7fff_ffff;
   localparam logic [olib_pkg::VAL_W-1:0] MIN_NEG = 32'h8000_0000;

   typedef struct {
      olib_pkg::status_type       st;
      logic [olib_pkg::POS_W-1:0] pos;
      logic [olib_pkg::POS_W-1:0] len;
      logic [olib_pkg::VAL_W-1:0] data;
   } list_beat_type;

   // Shadow of the list contents and the queue of beats still owed
   class list_shadow;
      logic [olib_pkg::VAL_W-1:0] vals[DEPTH];
      int                         links[DEPTH];
      int                         head = DEPTH;
      int                         fill = 0;
      list_beat_type              pending_beats[$];
      int                         errors = 0;
      int                         inserts_noted = 0;
      int                         reads_noted = 0;
      int                         outcome_hits[6] = '{default: 0};

      // apply one accepted command and queue the beat it must produce
      function void note_command(olib_pkg::op_type op, logic [olib_pkg::VAL_W-1:0] rv,
                                 logic [olib_pkg::VAL_W-1:0] nv,
                                 logic [olib_pkg::RP_W-1:0] rp);
         list_beat_type b;
         int            slot;
         int            prev;
         int            cur;
         int            p;
         int            i;
         bit            hit;
         b.st   = olib_pkg::ST_READ_RANGE;
         b.pos  = '0;
         b.data = '0;
         if (op == olib_pkg::OP_INSERT) begin
            inserts_noted++;
            if (fill >= DEPTH) begin
               b.st = olib_pkg::ST_FULL;
            end else begin
               slot       = fill;
               vals[slot] = nv;
               if (head >= DEPTH || vals[head] == rv) begin
                  // empty list or head matches: new head
                  links[slot] = head;
                  head        = slot;
                  b.st        = olib_pkg::ST_HEAD;
               end else begin
                  // walk from the head, first match wins
                  prev = head;
                  p    = 1;
                  hit  = 1'b0;
                  while (!hit && links[prev] < DEPTH) begin
                     cur = links[prev];
                     if (vals[cur] == rv) begin
                        links[slot] = cur;
                        links[prev] = slot;
                        hit         = 1'b1;
                        b.st        = olib_pkg::ST_BEFORE;
                        b.pos       = olib_pkg::POS_W'(p);
                     end else begin
                        prev = cur;
                        p++;
                     end
                  end
                  // no match: prepend and flag it
                  if (!hit) begin
                     links[slot] = head;
                     head        = slot;
                     b.st        = olib_pkg::ST_NOT_FOUND;
                  end
               end
               fill++;
            end
         end else begin
            reads_noted++;
            if (int'(rp) < fill) begin
               cur = head;
               for (i = 0; i < int'(rp); i++) cur = links[cur];
               b.st   = olib_pkg::ST_READ_OK;
               b.data = vals[cur];
            end
         end
         b.len = olib_pkg::POS_W'(fill);
         pending_beats.insert(pending_beats.size(), b);
      endfunction

      // compare one result beat with the oldest queued beat
      function void check_beat(logic [olib_pkg::ST_W-1:0] st,
                               logic [olib_pkg::POS_W-1:0] pos,
                               logic [olib_pkg::POS_W-1:0] len,
                               logic [olib_pkg::VAL_W-1:0] data);
         list_beat_type b;
         if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: result beat with no command pending (status %0d)", $time, st);
            return;
         end
         b = pending_beats.pop_front();
         outcome_hits[b.st]++;
         if (st !== b.st) begin
            errors++;
            $display("%0t: status: expected %0d, got %0d", $time, b.st, st);
         end
         if (pos !== b.pos) begin
            errors++;
            $display("%0t: insert_position: expected %0d, got %0d", $time, b.pos, pos);
         end
         if (len !== b.len) begin
            errors++;
            $display("%0t: list_length: expected %0d, got %0d", $time, b.len, len);
         end
         if (data !== b.data) begin
            errors++;
            $display("%0t: read_data: expected %h, got %h", $time, b.data, data);
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic                              req_op = 1'b0;
   logic signed [olib_pkg::VAL_W-1:0] req_ref_value = '0;
   logic signed [olib_pkg::VAL_W-1:0] req_new_value = '0;
   logic [olib_pkg::RP_W-1:0]         req_read_position = '0;
   logic                              rsp_valid;
   logic [olib_pkg::ST_W-1:0]         rsp_status;
   logic [olib_pkg::POS_W-1:0]        rsp_insert_position;
   logic [olib_pkg::POS_W-1:0]        rsp_list_length;
   logic signed [olib_pkg::VAL_W-1:0] rsp_read_data;

   list_shadow                 shadow;
   int                         idle_pct = 37;
   logic [olib_pkg::VAL_W-1:0] sent_values[$];
   int                         inserts_sent = 0;

   ordered_list_insert_before_core #(.LIST_DEPTH(DEPTH)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_ref_value       (req_ref_value),
      .req_new_value       (req_new_value),
      .req_read_position   (req_read_position),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_insert_position (rsp_insert_position),
      .rsp_list_length     (rsp_list_length),
      .rsp_read_data       (rsp_read_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Check result beats first, then note the command taken at this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         shadow.check_beat(rsp_status, rsp_insert_position, rsp_list_length, rsp_read_data);
      end
      if (!reset && start && !busy) begin
         shadow.note_command(olib_pkg::op_type'(req_op), req_ref_value, req_new_value,
                             req_read_position);
      end
   end

   // Present one command beat after a random gap and hold it until taken
   task automatic send_command(olib_pkg::op_type op, logic [olib_pkg::VAL_W-1:0] rv,
                               logic [olib_pkg::VAL_W-1:0] nv,
                               logic [olib_pkg::RP_W-1:0] rp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_op            <= op;
      req_ref_value     <= rv;
      req_new_value     <= nv;
      req_read_position <= rp;
      do @(posedge clock); while (busy);
      if (op == olib_pkg::OP_INSERT) begin
         sent_values.insert(sent_values.size(), nv);
         inserts_sent++;
      end
   endtask

   // Small values give duplicates, list values give hits deep in the walk
   function automatic logic [olib_pkg::VAL_W-1:0] pick_value(bit from_list);
      int r;
      r = $urandom_range(99);
      if (r < 30) return olib_pkg::VAL_W'($urandom_range(6)) - olib_pkg::VAL_W'(3);
      if (r < 40) return r[0] ? MAX_POS : MIN_NEG;
      if (from_list && sent_values.size() > 0 && r < 85) begin
         return sent_values[$urandom_range(sent_values.size() - 1)];
      end
      return $urandom;
   endfunction

   // Mostly in-range positions, some anywhere in the field
   function automatic logic [olib_pkg::RP_W-1:0] pick_position();
      int filled;
      filled = (inserts_sent < DEPTH) ? inserts_sent : DEPTH;
      if (filled > 0 && $urandom_range(99) < 80) begin
         return olib_pkg::RP_W'($urandom_range(filled - 1));
      end
      return olib_pkg::RP_W'($urandom_range(DEPTH - 1));
   endfunction

   // Watchdog: end the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("ordered_list_insert_before_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int n;
      shadow = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reads on the empty list
      send_command(olib_pkg::OP_READ, '0, '0, '0);
      send_command(olib_pkg::OP_READ, '1, '1, '1);
      // first insert lands in an empty list
      send_command(olib_pkg::OP_INSERT, '0, MAX_POS, '0);
      // head match, mid-list match, no match
      send_command(olib_pkg::OP_INSERT, MAX_POS, MIN_NEG, '0);
      send_command(olib_pkg::OP_INSERT, MAX_POS, '0, '0);
      send_command(olib_pkg::OP_INSERT, 32'd12345, '1, '1);
      send_command(olib_pkg::OP_INSERT, MAX_POS, '1, '0);
      // duplicate values: first match from the head wins
      send_command(olib_pkg::OP_INSERT, '1, 32'd7, '0);
      send_command(olib_pkg::OP_INSERT, '1, 32'd8, '0);
      send_command(olib_pkg::OP_INSERT, MAX_POS, 32'd5, '0);
      send_command(olib_pkg::OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 6'h2a);
      // read back every element, then just past the end and the far end
      for (n = 0; n < 10; n++) send_command(olib_pkg::OP_READ, '0, '0, olib_pkg::RP_W'(n));
      send_command(olib_pkg::OP_READ, '0, '0, 6'h3f);

      // random mix until well past a full store
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) idle_pct = 45;
         if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
         if ($urandom_range(99) < 30) begin
            send_command(olib_pkg::OP_INSERT, pick_value(1'b1), pick_value(1'b0),
                         olib_pkg::RP_W'($urandom));
         end else begin
            send_command(olib_pkg::OP_READ, pick_value(1'b1), pick_value(1'b0),
                         pick_position());
         end
      end
      start <= 1'b0;

      // drain, then allow a full walk for stray beats
      while (shadow.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d inserts and %0d reads, list filled to %0d of %0d entries",
               shadow.inserts_noted, shadow.reads_noted, shadow.fill, DEPTH);
      $display("outcomes before/head/not-found/full/read-ok/read-range: %0d/%0d/%0d/%0d/%0d/%0d",
               shadow.outcome_hits[0], shadow.outcome_hits[1], shadow.outcome_hits[2],
               shadow.outcome_hits[3], shadow.outcome_hits[4], shadow.outcome_hits[5]);
      if (shadow.errors == 0 && shadow.pending_beats.size() == 0) begin
         $display("ordered_list_insert_before_core_tb: PASS");
      end else begin
         $display("ordered_list_insert_before_core_tb: FAIL");
      end
      $finish;
   end

endmodule
